@@ sv/slsd_pkg.sv @@
package slsd_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_TOGGLE = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_END     = 2'd2;
    localparam logic [1:0] STAT_REFUSED = 2'd3;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_AP0   = 11'b000_0000_0010,
        S_AP1   = 11'b000_0000_0100,
        S_TWALK = 11'b000_0000_1000,
        S_TFREE = 11'b000_0001_0000,
        S_I0    = 11'b000_0010_0000,
        S_I1    = 11'b000_0100_0000,
        S_I2    = 11'b000_1000_0000,
        S_I3    = 11'b001_0000_0000,
        S_RD    = 11'b010_0000_0000,
        S_FIN   = 11'b100_0000_0000
    } state_t;

endpackage

@@ sv/static_list_symmetric_difference_unit.sv @@
// Set symmetric difference kept as a linked list in a node store of STORE_DEPTH entries,
// with a free list. One item is taken at a time; in_ready is high only while the sequencer
// is idle. Steps per item: clear goes to S_FIN; append runs S_AP0, S_AP1 (straight to
// S_FIN when refused or the store is full); read runs S_RD (not past the end of the
// list); toggle walks S_TWALK over k list nodes, compared one per cycle, up to
// STORE_DEPTH - 2, then S_TFREE when found, else S_I0 to S_I3 to insert a node. The
// result stays in an output register, so the next item is taken while it waits. No
// clearing pass is needed after reset: nodes never handed out are tracked by a fill mark.
module static_list_symmetric_difference_unit #(
    parameter int STORE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] element,
    output logic               is_last
);

    localparam int IW = $clog2(STORE_DEPTH);
    localparam int HW = $clog2(STORE_DEPTH + 1);
    localparam int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam logic [IW-1:0] HEAD = IW'(1);
    localparam logic [IW-1:0] LAST_NODE = IW'(STORE_DEPTH - 1);
    localparam logic [HW-1:0] DEPTH_H = HW'(STORE_DEPTH);

    logic [IW-1:0] link_mem [STORE_DEPTH];
    logic [SW-1:0] value_mem [STORE_DEPTH];

    slsd_pkg::state_t state_reg, state_next;
    logic [SW-1:0] val_reg, val_next;
    logic [IW-1:0] free_head_reg, free_head_next;
    logic [HW-1:0] fill_reg, fill_next;
    logic [IW-1:0] head_link_reg, head_link_next;
    logic [IW-1:0] a_tail_reg, a_tail_next;
    logic [IW-1:0] cursor_reg, cursor_next;
    logic          toggling_reg, toggling_next;
    logic [IW-1:0] prev_reg, prev_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] node_reg, node_next;
    logic [HW-1:0] steps_reg, steps_next;
    logic          restart_reg, restart_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [31:0]   res_elem_reg, res_elem_next;
    logic          res_last_reg, res_last_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    status_reg, status_next;
    logic [31:0]   element_reg, element_next;
    logic          is_last_reg, is_last_next;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          rd_head_reg;
    logic [IW-1:0] link_q;
    logic [SW-1:0] val_q;
    logic          lw_en;
    logic [IW-1:0] lw_addr;
    logic [IW-1:0] lw_data;
    logic          vw_en;
    logic [IW-1:0] vw_addr;
    logic [SW-1:0] vw_data;

    logic [IW-1:0] link_rd;
    logic [IW-1:0] link_b;
    logic          node_fresh;
    logic [IW-1:0] fresh_next;
    logic          accept;

    assign in_ready  = (state_reg == slsd_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign element   = element_reg;
    assign is_last   = is_last_reg;

    assign link_rd    = rd_head_reg ? head_link_reg : link_q;
    assign link_b     = (HW'(link_rd) < DEPTH_H) ? link_rd : '0;
    assign node_fresh = (HW'(node_reg) >= fill_reg);
    assign fresh_next = (node_reg == LAST_NODE) ? '0 : node_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            link_q <= link_mem[rd_addr];
            val_q  <= value_mem[rd_addr];
        end
        if (lw_en && lw_addr != HEAD)
        begin
            link_mem[lw_addr] <= lw_data;
        end
        if (vw_en)
        begin
            value_mem[vw_addr] <= vw_data;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        val_next        = val_reg;
        free_head_next  = free_head_reg;
        fill_next       = fill_reg;
        head_link_next  = head_link_reg;
        a_tail_next     = a_tail_reg;
        cursor_next     = cursor_reg;
        toggling_next   = toggling_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        node_next       = node_reg;
        steps_next      = steps_reg;
        restart_next    = restart_reg;
        res_status_next = res_status_reg;
        res_elem_next   = res_elem_reg;
        res_last_next   = res_last_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        element_next    = element_reg;
        is_last_next    = is_last_reg;
        rd_en   = 1'b0;
        rd_addr = node_reg;
        lw_en   = 1'b0;
        lw_addr = node_reg;
        lw_data = '0;
        vw_en   = 1'b0;
        vw_addr = node_reg;
        vw_data = val_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            slsd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    val_next        = value[SW-1:0];
                    res_status_next = slsd_pkg::STAT_OK;
                    res_elem_next   = '0;
                    res_last_next   = 1'b0;
                    restart_next    = 1'b0;
                    state_next      = slsd_pkg::S_FIN;
                    case (command)
                        slsd_pkg::CMD_CLEAR:
                        begin
                            free_head_next = IW'(2);
                            fill_next      = HW'(2);
                            head_link_next = '0;
                            a_tail_next    = HEAD;
                            cursor_next    = '0;
                            toggling_next  = 1'b0;
                        end
                        slsd_pkg::CMD_APPEND:
                        begin
                            if (toggling_reg)
                            begin
                                res_status_next = slsd_pkg::STAT_REFUSED;
                            end
                            else if (free_head_reg == '0)
                            begin
                                res_status_next = slsd_pkg::STAT_FULL;
                                restart_next    = 1'b1;
                            end
                            else
                            begin
                                node_next  = free_head_reg;
                                state_next = slsd_pkg::S_AP0;
                            end
                        end
                        slsd_pkg::CMD_TOGGLE:
                        begin
                            toggling_next = 1'b1;
                            prev_next     = HEAD;
                            cur_next      = head_link_reg;
                            steps_next    = '0;
                            if (head_link_reg == '0)
                            begin
                                state_next = slsd_pkg::S_I0;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_link_reg;
                                state_next = slsd_pkg::S_TWALK;
                            end
                        end
                        default:
                        begin
                            if (cursor_reg == '0)
                            begin
                                res_status_next = slsd_pkg::STAT_END;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = cursor_reg;
                                state_next = slsd_pkg::S_RD;
                            end
                        end
                    endcase
                end
            end
            slsd_pkg::S_AP0:
            begin
                rd_en       = 1'b1;
                rd_addr     = node_reg;
                vw_en       = 1'b1;
                lw_en       = 1'b1;
                lw_addr     = a_tail_reg;
                lw_data     = node_reg;
                a_tail_next = node_reg;
                state_next  = slsd_pkg::S_AP1;
            end
            slsd_pkg::S_AP1:
            begin
                if (node_fresh)
                begin
                    free_head_next = fresh_next;
                    fill_next      = fill_reg + 1'b1;
                end
                else
                begin
                    free_head_next = link_b;
                end
                lw_en        = 1'b1;
                lw_addr      = node_reg;
                lw_data      = '0;
                restart_next = 1'b1;
                state_next   = slsd_pkg::S_FIN;
            end
            slsd_pkg::S_TWALK:
            begin
                if (val_q == val_reg)
                begin
                    lw_en   = 1'b1;
                    lw_addr = prev_reg;
                    lw_data = link_b;
                    if (cur_reg == a_tail_reg)
                    begin
                        a_tail_next = prev_reg;
                    end
                    state_next = slsd_pkg::S_TFREE;
                end
                else if (steps_reg == DEPTH_H)
                begin
                    state_next = slsd_pkg::S_I0;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_b;
                    steps_next = steps_reg + 1'b1;
                    if (link_b == '0)
                    begin
                        state_next = slsd_pkg::S_I0;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = link_b;
                    end
                end
            end
            slsd_pkg::S_TFREE:
            begin
                lw_en          = 1'b1;
                lw_addr        = cur_reg;
                lw_data        = free_head_reg;
                free_head_next = cur_reg;
                restart_next   = 1'b1;
                state_next     = slsd_pkg::S_FIN;
            end
            slsd_pkg::S_I0:
            begin
                if (free_head_reg == '0)
                begin
                    res_status_next = slsd_pkg::STAT_FULL;
                    restart_next    = 1'b1;
                    state_next      = slsd_pkg::S_FIN;
                end
                else
                begin
                    node_next  = free_head_reg;
                    rd_en      = 1'b1;
                    rd_addr    = free_head_reg;
                    state_next = slsd_pkg::S_I1;
                end
            end
            slsd_pkg::S_I1:
            begin
                if (node_fresh)
                begin
                    free_head_next = fresh_next;
                    fill_next      = fill_reg + 1'b1;
                end
                else
                begin
                    free_head_next = link_b;
                end
                rd_en      = 1'b1;
                rd_addr    = a_tail_reg;
                state_next = slsd_pkg::S_I2;
            end
            slsd_pkg::S_I2:
            begin
                lw_en      = 1'b1;
                lw_addr    = node_reg;
                lw_data    = link_b;
                vw_en      = 1'b1;
                state_next = slsd_pkg::S_I3;
            end
            slsd_pkg::S_I3:
            begin
                lw_en        = 1'b1;
                lw_addr      = a_tail_reg;
                lw_data      = node_reg;
                restart_next = 1'b1;
                state_next   = slsd_pkg::S_FIN;
            end
            slsd_pkg::S_RD:
            begin
                res_elem_next = 32'(val_q);
                cursor_next   = link_b;
                res_last_next = (link_b == '0);
                state_next    = slsd_pkg::S_FIN;
            end
            slsd_pkg::S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    element_next   = res_elem_reg;
                    is_last_next   = res_last_reg;
                    if (restart_reg)
                    begin
                        cursor_next = head_link_reg;
                    end
                    state_next = slsd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = slsd_pkg::S_IDLE;
            end
        endcase

        // the list head's link lives in a register
        if (lw_en && lw_addr == HEAD)
        begin
            head_link_next = lw_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slsd_pkg::S_IDLE;
            free_head_reg <= IW'(2);
            fill_reg      <= HW'(2);
            head_link_reg <= '0;
            a_tail_reg    <= HEAD;
            cursor_reg    <= '0;
            toggling_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_head_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            head_link_reg <= head_link_next;
            a_tail_reg    <= a_tail_next;
            cursor_reg    <= cursor_next;
            toggling_reg  <= toggling_next;
            out_valid_reg <= out_valid_next;
            if (rd_en)
            begin
                rd_head_reg <= (rd_addr == HEAD);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg        <= val_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        node_reg       <= node_next;
        steps_reg      <= steps_next;
        restart_reg    <= restart_next;
        res_status_reg <= res_status_next;
        res_elem_reg   <= res_elem_next;
        res_last_reg   <= res_last_next;
        status_reg     <= status_next;
        element_reg    <= element_next;
        is_last_reg    <= is_last_next;
    end

endmodule
